>>> hdl/spdq_pkg.sv
// ----------------------------------------------------------------------------
// spdq_pkg: shared types and constants of the packet queue latency dropper.
// Holds the word field widths, the operation and register codes and the
// layout of one queue entry.
// ----------------------------------------------------------------------------
package spdq_pkg;

  localparam int KIND_W   = 2;
  localparam int STAMP_W  = 32;
  localparam int PRIO_W   = 2;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 9;
  localparam int THR_W    = 16;

  localparam int QUEUE_DEPTH = 256;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DROP_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_AUDIO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_THR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTER_THR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_THR     = 3'd4;

  typedef struct packed {
    logic [STAMP_W-1:0]  stamp;
    logic                vid;
    logic                aud;
    logic                key;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic             drop_enable;
    logic             drop_audio;
    logic [THR_W-1:0] base_thr;
    logic [THR_W-1:0] inter_thr;
    logic [THR_W-1:0] key_thr;
  } cfg_t;

endpackage

>>> hdl/spdq_ifs.sv
// ----------------------------------------------------------------------------
// spdq_ifs: request and response channels of the packet queue.
// Each word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface spdq_req_if import spdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [STAMP_W-1:0]  stamp_ms;
  logic                is_video;
  logic                is_audio;
  logic                is_key;
  logic [PRIO_W-1:0]   prio;
  logic [HANDLE_W-1:0] handle;

  modport source (output valid, kind, stamp_ms, is_video, is_audio, is_key, prio, handle,
                  input ready);
  modport sink (input valid, kind, stamp_ms, is_video, is_audio, is_key, prio, handle,
                output ready);
endinterface

interface spdq_rsp_if import spdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                rejected;
  logic [COUNT_W-1:0]  dropped;
  logic [COUNT_W-1:0]  fill;
  logic [STAMP_W-1:0]  span_ms;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_handle;
  logic [STAMP_W-1:0]  out_stamp_ms;
  logic [STAMP_W-1:0]  start_offset_ms;

  modport source (output valid, rejected, dropped, fill, span_ms, out_valid, out_handle,
                  out_stamp_ms, start_offset_ms, input ready);
  modport sink (input valid, rejected, dropped, fill, span_ms, out_valid, out_handle,
                out_stamp_ms, start_offset_ms, output ready);
endinterface

>>> hdl/stream_packet_queue_latency_dropper_unit.sv
// ----------------------------------------------------------------------------
// stream_packet_queue_latency_dropper_unit: media packet queue with latency drop.
// A circular buffer in one memory; a sequencer scans it one entry per cycle.
// Restart, reject, empty pop and a push into an empty queue go straight to the result;
// other pushes below the minimum fill read the oldest entry to measure the span.
// From the minimum fill a push scans the queue for the span and may run a drop tier.
// Pop: delivers the head entry, after a key search if needed; an offset search ends the pop.
// One word is in work at a time; a stalled result holds the sequencer.
// Synchronous reset empties the queue; memory contents are not cleared.
// ----------------------------------------------------------------------------
module stream_packet_queue_latency_dropper_unit import spdq_pkg::*; #(
  parameter int MIN_FILL    = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  spdq_req_if.sink              req,
  spdq_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FIRST, S_MEAS, S_EVAL, S_GUARD, S_COMPACT, S_KEY, S_OFF, S_DLV, S_FIN
  } state_t;

  typedef logic signed [STAMP_W+1:0] wide_t;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) sum = sum - (CW+1)'(QUEUE_DEPTH);
    return sum[AW-1:0];
  endfunction

  function automatic wide_t sx(input logic [STAMP_W-1:0] v);
    return $signed({2'b00, v});
  endfunction

  cfg_t cfg;

  spdq_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .we   (cfg_we),
    .idx  (cfg_idx),
    .data (cfg_data),
    .cfg  (cfg)
  );

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data;
  logic   rd_en;
  logic   [AW-1:0] rd_addr;
  logic   wr_en;
  logic   [AW-1:0] wr_addr;
  entry_t wr_data;

  state_t state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic key_seen;
  logic offset_valid;
  logic [STAMP_W-1:0] start_offset;

  logic [CW-1:0] idx;
  logic [CW-1:0] pidx;
  logic [CW-1:0] wpos;
  logic pend;
  logic [STAMP_W-1:0] ns;
  logic [STAMP_W-1:0] fv, lv, fa, la;
  logic [1:0] nv, na;
  logic [THR_W-1:0] thr;
  logic [1:0] rule;
  logic vf, af;
  logic [STAMP_W-1:0] sv, sa;

  logic r_rej;
  logic [CW-1:0] r_drop;
  logic [STAMP_W-1:0] r_span;
  logic r_ov;
  logic [HANDLE_W-1:0] r_oh;
  logic [STAMP_W-1:0] r_os;

  logic o_valid;
  logic o_rej;
  logic [COUNT_W-1:0] o_drop;
  logic [COUNT_W-1:0] o_fill;
  logic [STAMP_W-1:0] o_span;
  logic o_ov;
  logic [HANDLE_W-1:0] o_oh;
  logic [STAMP_W-1:0] o_os;
  logic [STAMP_W-1:0] o_off;

  logic issue;
  logic scan_done;
  logic kill;
  logic guard_hit;
  logic take_v, take_a;
  logic [STAMP_W-1:0] sv_n, sa_n;
  logic hv, ha;
  wide_t vspan, span, diff;
  logic [STAMP_W-1:0] lo, hi;
  entry_t in_entry;

  assign req.ready = (state == S_IDLE);

  assign in_entry.stamp  = req.stamp_ms;
  assign in_entry.vid    = req.is_video;
  assign in_entry.aud    = req.is_audio;
  assign in_entry.key    = req.is_key;
  assign in_entry.prio   = req.prio;
  assign in_entry.handle = req.handle;

  always_comb begin
    case (state)
      S_FIRST, S_DLV:        issue = (idx == '0);
      S_MEAS, S_GUARD,
      S_KEY, S_OFF:          issue = (idx < count);
      S_COMPACT:             issue = (idx != '0);
      default:               issue = 1'b0;
    endcase
    rd_en     = issue;
    rd_addr   = wrap(head, (state == S_COMPACT) ? idx - 1'b1 : idx);
    scan_done = !pend && !issue;
  end

  always_comb begin
    if (rule == 2'd3) kill = cfg.drop_audio || !rd_data.aud;
    else              kill = (rd_data.prio <= rule) && rd_data.vid;
    diff      = sx(ns) - sx(rd_data.stamp);
    guard_hit = rd_data.key && (diff < $signed({18'b0, thr}));
    take_v    = rd_data.vid && !vf;
    take_a    = !take_v && rd_data.aud && !af;
    sv_n      = take_v ? rd_data.stamp : sv;
    sa_n      = take_a ? rd_data.stamp : sa;
  end

  always_comb begin
    hv    = (nv == 2'd2);
    ha    = (na == 2'd2);
    vspan = hv ? sx(lv) - sx(fv) : '0;
    lo    = fv;
    hi    = lv;
    if (hv && ha) begin
      lo = (fa < fv) ? fa : fv;
      hi = (la > lv) ? la : lv;
    end else if (ha) begin
      lo = fa;
      hi = la;
    end
    span = (hv || ha) ? sx(hi) - sx(lo) : '0;
  end

  always_comb begin
    if (state == S_COMPACT) begin
      wr_en   = pend && !kill;
      wr_addr = wrap(head, wpos - 1'b1);
      wr_data = rd_data;
    end else begin
      wr_en   = (state == S_IDLE) && req.valid && (req.kind == KIND_PUSH) &&
                (count != CW'(QUEUE_DEPTH));
      wr_addr = wrap(head, count);
      wr_data = in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      key_seen     <= 1'b0;
      offset_valid <= 1'b0;
      start_offset <= '0;
      pend         <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      pend <= issue;
      if (issue) begin
        pidx <= (state == S_COMPACT) ? idx - 1'b1 : idx;
        idx  <= (state == S_COMPACT) ? idx - 1'b1 : idx + 1'b1;
      end
      if (o_valid && rsp.ready) o_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_rej  <= 1'b0;
            r_drop <= '0;
            r_span <= '0;
            r_ov   <= 1'b0;
            r_oh   <= '0;
            r_os   <= '0;
            idx    <= '0;
            pend   <= 1'b0;
            nv     <= '0;
            na     <= '0;
            vf     <= 1'b0;
            af     <= 1'b0;
            ns     <= req.stamp_ms;
            state  <= S_FIN;
            case (req.kind)
              KIND_PUSH: begin
                if (count == CW'(QUEUE_DEPTH)) begin
                  r_rej <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                  if (32'(count) + 32'd1 >= 32'(MIN_FILL)) state <= S_MEAS;
                  else if (count != '0)                    state <= S_FIRST;
                end
              end
              KIND_POP: begin
                if (count != '0) begin
                  if (!key_seen)          state <= S_KEY;
                  else if (!offset_valid) state <= S_OFF;
                  else                    state <= S_DLV;
                end
              end
              KIND_RESTART: begin
                count        <= '0;
                key_seen     <= 1'b0;
                offset_valid <= 1'b0;
                start_offset <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_FIRST: begin
          if (pend) begin
            r_span <= ns - rd_data.stamp;
            state  <= S_FIN;
          end
        end
        S_MEAS: begin
          if (pend) begin
            if (rd_data.vid) begin
              if (nv == 2'd0) fv <= rd_data.stamp;
              lv <= rd_data.stamp;
              if (nv != 2'd2) nv <= nv + 1'b1;
            end
            if (rd_data.aud) begin
              if (na == 2'd0) fa <= rd_data.stamp;
              la <= rd_data.stamp;
              if (na != 2'd2) na <= na + 1'b1;
            end
          end
          if (scan_done) state <= S_EVAL;
        end
        S_EVAL: begin
          r_span <= span[STAMP_W-1:0];
          idx    <= '0;
          pend   <= 1'b0;
          state  <= S_FIN;
          if (cfg.drop_enable && !(vspan <= $signed({18'b0, cfg.base_thr}) &&
                                   span <= $signed({18'b0, cfg.key_thr}))) begin
            if (span > $signed({18'b0, cfg.key_thr})) begin
              thr   <= cfg.key_thr;
              rule  <= 2'd3;
              state <= S_GUARD;
            end else if (span > $signed({18'b0, cfg.inter_thr})) begin
              thr   <= cfg.inter_thr;
              rule  <= 2'd2;
              state <= S_GUARD;
            end else if (span > $signed({18'b0, cfg.base_thr})) begin
              thr   <= cfg.base_thr;
              rule  <= 2'd1;
              state <= S_GUARD;
            end
          end
        end
        S_GUARD: begin
          if (pend && guard_hit) begin
            pend  <= 1'b0;
            idx   <= pidx;
            wpos  <= pidx;
            state <= (pidx == '0) ? S_FIN : S_COMPACT;
          end else if (scan_done) begin
            state <= S_FIN;
          end
        end
        S_COMPACT: begin
          if (pend) begin
            if (kill) r_drop <= r_drop + 1'b1;
            else      wpos   <= wpos - 1'b1;
          end
          if (scan_done) begin
            head  <= wrap(head, r_drop);
            count <= count - r_drop;
            state <= S_FIN;
          end
        end
        S_KEY: begin
          if (pend && rd_data.vid && rd_data.key) begin
            key_seen <= 1'b1;
            head     <= wrap(head, pidx);
            count    <= count - pidx;
            idx      <= '0;
            pend     <= 1'b0;
            state    <= offset_valid ? S_DLV : S_OFF;
          end else if (scan_done) begin
            count <= '0;
            state <= S_FIN;
          end
        end
        S_OFF: begin
          if (pend) begin
            vf <= vf || take_v;
            af <= af || take_a;
            sv <= sv_n;
            sa <= sa_n;
            if ((vf || take_v) && (af || take_a)) begin
              start_offset <= (sv_n < sa_n) ? sv_n : sa_n;
              offset_valid <= 1'b1;
              pend         <= 1'b0;
              state        <= S_FIN;
            end
          end
          if (scan_done) state <= S_FIN;
        end
        S_DLV: begin
          if (pend) begin
            r_ov  <= 1'b1;
            r_oh  <= rd_data.handle;
            r_os  <= rd_data.stamp;
            head  <= wrap(head, CW'(1));
            count <= count - 1'b1;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_rej   <= r_rej;
            o_drop  <= COUNT_W'(r_drop);
            o_fill  <= COUNT_W'(count);
            o_span  <= r_span;
            o_ov    <= r_ov;
            o_oh    <= r_oh;
            o_os    <= r_os;
            o_off   <= offset_valid ? start_offset : '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid           = o_valid;
  assign rsp.rejected        = o_rej;
  assign rsp.dropped         = o_drop;
  assign rsp.fill            = o_fill;
  assign rsp.span_ms         = o_span;
  assign rsp.out_valid       = o_ov;
  assign rsp.out_handle      = o_oh;
  assign rsp.out_stamp_ms    = o_os;
  assign rsp.start_offset_ms = o_off;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue fill exceeds depth");

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.kind == KIND_RESTART) |=> (count == '0 && !key_seen))
    else $error("restart did not clear the queue");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_rej) |-> (o_drop == '0 && !o_ov))
    else $error("rejected word reports a drop or delivery");

endmodule

>>> hdl/spdq_cfg.sv
// ----------------------------------------------------------------------------
// spdq_cfg: configuration registers of the packet queue.
// Decodes the write port and holds the drop controls and thresholds.
// ----------------------------------------------------------------------------
module spdq_cfg import spdq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [CFG_IDX_W-1:0]  idx,
  input  logic [CFG_DATA_W-1:0] data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drop_enable <= 1'b1;
      cfg.drop_audio  <= 1'b0;
      cfg.base_thr    <= 16'd1000;
      cfg.inter_thr   <= 16'd2000;
      cfg.key_thr     <= 16'd3000;
    end else if (we) begin
      case (idx)
        REG_DROP_ENABLE: cfg.drop_enable <= data[0];
        REG_DROP_AUDIO:  cfg.drop_audio  <= data[0];
        REG_BASE_THR:    cfg.base_thr    <= data;
        REG_INTER_THR:   cfg.inter_thr   <= data;
        REG_KEY_THR:     cfg.key_thr     <= data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> tb/spdq_tb_ifs.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spdq_tb_ifs: testbench side helpers for the packet queue channels.
// The channels themselves are the interfaces of the design; this file holds
// the word layouts that the checker keeps for the request and response.
// ----------------------------------------------------------------------------
package spdq_tb_pkg;
  import spdq_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [STAMP_W-1:0]  stamp_ms;
    logic                is_video;
    logic                is_audio;
    logic                is_key;
    logic [PRIO_W-1:0]   prio;
    logic [HANDLE_W-1:0] handle;
  } req_word_t;

  typedef struct packed {
    logic                rejected;
    logic [COUNT_W-1:0]  dropped;
    logic [COUNT_W-1:0]  fill;
    logic [STAMP_W-1:0]  span_ms;
    logic                out_valid;
    logic [HANDLE_W-1:0] out_handle;
    logic [STAMP_W-1:0]  out_stamp_ms;
    logic [STAMP_W-1:0]  start_offset_ms;
  } rsp_word_t;
endpackage

>>> tb/stream_packet_queue_latency_dropper_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Packet queue latency dropper testbench
// Drives push, pop and restart words with bursty input and a stalling
// output, predicts every response with a queue model held in a scoreboard
// class, and compares the responses field by field in arrival order.
// ----------------------------------------------------------------------------
module stream_packet_queue_latency_dropper_unit_tb;
  import spdq_pkg::*;
  import spdq_tb_pkg::*;

  localparam int DEPTH = 256;
  localparam int MINF  = 5;
  localparam int LIMIT = 3000000;

  class queue_scoreboard;
    entry_t    slots[$];
    bit        key_seen, offset_valid;
    logic [31:0] start_offset;
    cfg_t      cfg;
    rsp_word_t pending[$];
    int        errors;

    function void clear_state();
      slots.delete();
      key_seen = 0;
      offset_valid = 0;
      start_offset = 0;
      cfg.drop_enable = 1;
      cfg.drop_audio = 0;
      cfg.base_thr = 1000;
      cfg.inter_thr = 2000;
      cfg.key_thr = 3000;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
      case (idx)
        REG_DROP_ENABLE: cfg.drop_enable = val[0];
        REG_DROP_AUDIO:  cfg.drop_audio = val[0];
        REG_BASE_THR:    cfg.base_thr = val;
        REG_INTER_THR:   cfg.inter_thr = val;
        REG_KEY_THR:     cfg.key_thr = val;
        default: ;
      endcase
    endfunction

    function int drop_by_tier(longint thr, int rule);
      longint lastst;
      int guard, dropped;
      bit kill;
      entry_t kept[$];
      guard = 0;
      dropped = 0;
      lastst = slots[slots.size()-1].stamp;
      for (int i = 0; i < slots.size(); i++) begin
        if (slots[i].key && lastst - longint'(slots[i].stamp) < thr) begin
          guard = i;
          break;
        end
      end
      foreach (slots[i]) begin
        kill = 0;
        if (i < guard) begin
          if (rule == 3) kill = cfg.drop_audio || !slots[i].aud;
          else kill = slots[i].prio <= rule && slots[i].vid;
        end
        if (kill) dropped++;
        else kept.insert(kept.size(), slots[i]);
      end
      slots = kept;
      return dropped;
    endfunction

    function int apply_drop(output longint span);
      int fv, lv, fa, la;
      longint lo, hi, vspan, a, b;
      fv = -1; lv = -1; fa = -1; la = -1;
      if (slots.size() < MINF) begin
        span = slots[slots.size()-1].stamp - longint'(slots[0].stamp);
        return 0;
      end
      foreach (slots[i]) begin
        if (slots[i].vid) begin if (fv < 0) fv = i; lv = i; end
        if (slots[i].aud) begin if (fa < 0) fa = i; la = i; end
      end
      lo = 64'h7fffffffffffffff;
      hi = 64'h8000000000000000;
      span = 0;
      vspan = 0;
      if (fv != lv) begin
        a = slots[fv].stamp; b = slots[lv].stamp;
        vspan = b - a;
        if (a < lo) lo = a;
        if (b > hi) hi = b;
      end
      if (fa != la) begin
        a = slots[fa].stamp; b = slots[la].stamp;
        if (a < lo) lo = a;
        if (b > hi) hi = b;
      end
      if (lo != 64'h7fffffffffffffff && hi != 64'h8000000000000000) span = hi - lo;
      if (!cfg.drop_enable) return 0;
      if (vspan <= longint'(cfg.base_thr) && span <= longint'(cfg.key_thr)) return 0;
      if (span > longint'(cfg.key_thr)) return drop_by_tier(cfg.key_thr, 3);
      if (span > longint'(cfg.inter_thr)) return drop_by_tier(cfg.inter_thr, 2);
      if (span > longint'(cfg.base_thr)) return drop_by_tier(cfg.base_thr, 1);
      return 0;
    endfunction

    function void try_fix_offset();
      int v, a;
      v = -1; a = -1;
      foreach (slots[i]) begin
        if (slots[i].vid && v < 0) v = i;
        else if (slots[i].aud && a < 0) a = i;
        if (v >= 0 && a >= 0) begin
          start_offset = slots[v].stamp < slots[a].stamp ? slots[v].stamp : slots[a].stamp;
          offset_valid = 1;
          return;
        end
      end
    endfunction

    function void note_request(req_word_t w);
      rsp_word_t r;
      entry_t e;
      longint sp;
      int i;
      r = '{default: 0};
      if (w.kind == KIND_PUSH) begin
        if (slots.size() >= DEPTH) r.rejected = 1;
        else begin
          e.stamp = w.stamp_ms; e.vid = w.is_video; e.aud = w.is_audio;
          e.key = w.is_key; e.prio = w.prio; e.handle = w.handle;
          slots.insert(slots.size(), e);
          r.dropped = COUNT_W'(apply_drop(sp));
          r.span_ms = sp[31:0];
        end
      end else if (w.kind == KIND_POP) begin
        if (slots.size() > 0) begin
          if (!key_seen) begin
            i = 0;
            while (i < slots.size() && !(slots[i].vid && slots[i].key)) i++;
            if (i < slots.size()) key_seen = 1;
            repeat (i) slots.delete(0);
          end
          if (key_seen) begin
            if (!offset_valid) try_fix_offset();
            else if (slots.size() > 0) begin
              e = slots[0];
              slots.delete(0);
              r.out_valid = 1;
              r.out_handle = e.handle;
              r.out_stamp_ms = e.stamp;
            end
          end
        end
      end else if (w.kind == KIND_RESTART) begin
        slots.delete();
        key_seen = 0;
        offset_valid = 0;
        start_offset = 0;
      end
      r.fill = COUNT_W'(slots.size());
      r.start_offset_ms = offset_valid ? start_offset : 0;
      pending.insert(pending.size(), r);
    endfunction

    function void check_response(rsp_word_t got);
      rsp_word_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response fill=%0d", $realtime, got.fill);
        errors++;
        return;
      end
      x = pending[0];
      pending.delete(0);
      if (got !== x) begin
        errors++;
        $display("%0t: expected rej=%0d drop=%0d fill=%0d span=%0d ov=%0d oh=%0d os=%0d off=%0d",
                 $realtime, x.rejected, x.dropped, x.fill, x.span_ms, x.out_valid,
                 x.out_handle, x.out_stamp_ms, x.start_offset_ms);
        $display("%0t: actual   rej=%0d drop=%0d fill=%0d span=%0d ov=%0d oh=%0d os=%0d off=%0d",
                 $realtime, got.rejected, got.dropped, got.fill, got.span_ms, got.out_valid,
                 got.out_handle, got.out_stamp_ms, got.start_offset_ms);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  spdq_req_if req ();
  spdq_rsp_if rsp ();

  stream_packet_queue_latency_dropper_unit dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  queue_scoreboard board;
  int cycles = 0;
  int hold_off = 0;
  int stall_mode = 0;
  logic [31:0] stamp_now = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  function void rspword_t_sample();
    rsp_word_t g;
    if (!rst && req.valid && req.ready) begin
      board.note_request('{req.kind, req.stamp_ms, req.is_video, req.is_audio,
                           req.is_key, req.prio, req.handle});
    end
    if (!rst && rsp.valid && rsp.ready) begin
      g.rejected = rsp.rejected; g.dropped = rsp.dropped; g.fill = rsp.fill;
      g.span_ms = rsp.span_ms; g.out_valid = rsp.out_valid; g.out_handle = rsp.out_handle;
      g.out_stamp_ms = rsp.out_stamp_ms; g.start_offset_ms = rsp.start_offset_ms;
      board.check_response(g);
    end
  endfunction

  always @(posedge clk) begin
    rspword_t_sample();
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 0;
    end else if (hold_off > 0) begin
      hold_off--;
      rsp.ready <= 0;
    end else begin
      case (stall_mode)
        0: rsp.ready <= 1;
        1: rsp.ready <= ($urandom_range(0, 3) != 0);
        default: rsp.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic send_word(req_word_t w);
    req.valid <= 1;
    req.kind <= w.kind; req.stamp_ms <= w.stamp_ms; req.is_video <= w.is_video;
    req.is_audio <= w.is_audio; req.is_key <= w.is_key; req.prio <= w.prio;
    req.handle <= w.handle;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic pause_sender();
    req.valid <= 0;
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    board.write_reg(idx, val);
  endtask

  task automatic drain_all();
    req.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  function automatic req_word_t make_push(int flavor);
    req_word_t w;
    stamp_now += $urandom_range(0, 300);
    w.kind = KIND_PUSH;
    w.stamp_ms = ($urandom_range(0, 30) == 0) ? $urandom() : stamp_now;
    w.is_video = 1'($urandom_range(0, 1));
    w.is_audio = (flavor != 0) ? !w.is_video : 1'($urandom_range(0, 1));
    w.is_key = w.is_video ? ($urandom_range(0, 5) == 0) : $urandom_range(0, 9) == 0;
    w.prio = PRIO_W'($urandom_range(0, 3));
    w.handle = HANDLE_W'($urandom());
    return w;
  endfunction

  function automatic req_word_t make_word();
    req_word_t w;
    int r;
    r = $urandom_range(0, 99);
    w = make_push(r < 90);
    if (r >= 60 && r < 93) w.kind = KIND_POP;
    else if (r >= 93 && r < 95) w.kind = KIND_RESTART;
    else if (r == 95) w.kind = KIND_UNKNOWN;
    return w;
  endfunction

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_word(make_word());
        count--;
      end
      if ($urandom_range(0, 2) != 0) pause_sender();
    end
  endtask

  initial begin
    req_word_t w;
    req.valid = 0; req.kind = KIND_PUSH; req.stamp_ms = 0; req.is_video = 0;
    req.is_audio = 0; req.is_key = 0; req.prio = 0; req.handle = 0;
    board = new();
    board.clear_state();
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    stall_mode = 1;
    w = '{KIND_POP, 32'd0, 1'b0, 1'b0, 1'b0, 2'd0, 16'd0};
    send_word(w);
    w = '{KIND_PUSH, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 2'd3, 16'hFFFF};
    send_word(w);
    w = '{KIND_PUSH, 32'd0, 1'b0, 1'b1, 1'b1, 2'd0, 16'd0};
    send_word(w);
    w.kind = KIND_POP;
    send_word(w);
    w = '{KIND_PUSH, 32'd100, 1'b1, 1'b1, 1'b1, 2'd1, 16'h1234};
    send_word(w);
    for (int i = 0; i < 8; i++) begin
      w = '{KIND_PUSH, STAMP_W'(200 + i * 1500), i[0], !i[0], i % 3 == 0,
            PRIO_W'(i % 4), HANDLE_W'(i)};
      send_word(w);
    end
    w.kind = KIND_POP;
    repeat (4) send_word(w);
    w.kind = KIND_UNKNOWN;
    send_word(w);
    w.kind = KIND_RESTART;
    send_word(w);

    random_phase(300);
    drain_all();
    write_reg(REG_DROP_ENABLE, 0);
    write_reg(REG_DROP_AUDIO, 1);
    write_reg(REG_BASE_THR, 0);
    write_reg(REG_INTER_THR, 0);
    write_reg(REG_KEY_THR, 0);
    stall_mode = 2;
    random_phase(150);

    drain_all();
    write_reg(REG_DROP_ENABLE, 1);
    stall_mode = 0;
    random_phase(250);

    drain_all();
    write_reg(REG_BASE_THR, 16'hFFFF);
    write_reg(REG_INTER_THR, 16'hFFFF);
    write_reg(REG_KEY_THR, 16'hFFFF);
    write_reg(REG_DROP_AUDIO, 0);
    stall_mode = 1;
    hold_off = 4000;
    for (int i = 0; i < 300; i++) send_word(make_push(1));
    random_phase(200);

    drain_all();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
